[hw/rtl/aoss_pkg.sv]
package aoss_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SUM_W = 16;
  localparam int unsigned PHYS_W = 4;
  localparam int unsigned PHYS_N = 16;
  localparam int unsigned SIM_W = 8;
  localparam int unsigned PASS_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RPT_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIM_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSES = 2'd2;

  localparam logic [PHYS_N-1:0] ENABLE_MASK_RESET = 16'h00ff;
  localparam logic [SIM_W-1:0] SIM_MASK_RESET = 8'h00;
  localparam logic [PASS_W-1:0] PASSES_RESET = 7'd8;

  // Result kinds.
  localparam logic KIND_SELECT = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [PHYS_N-1:0] enable_mask;
    logic [SIM_W-1:0]  sim_mask;
    logic [PASS_W-1:0] passes;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_RPT_RD,
    ST_RPT_OUT,
    ST_SEL
  } state_e;

  // Position of the n-th set bit of the enable mask, counting from bit 0, or 0 if
  // the mask has too few set bits. Every bit position is checked independently.
  function automatic logic [PHYS_W-1:0] nth_enabled(logic [PHYS_N-1:0] mask,
                                                    logic [IDX_W-1:0] n);
    logic [PHYS_W-1:0] res;
    logic [PHYS_N-1:0] below;
    logic [PHYS_W:0]   cnt;
    res = '0;
    for (int b = 0; b < PHYS_N; b++) begin
      below = mask & ((PHYS_N'(1) << b) - PHYS_N'(1));
      cnt = (PHYS_W + 1)'($countones(below));
      if (mask[b] && (cnt == (PHYS_W + 1)'(n))) begin
        res = PHYS_W'(b);
      end
    end
    return res;
  endfunction

endpackage

[hw/rtl/adc_oversampling_scan_sequencer_unit.sv]
// Round-robin oversampling scan sequencer for an 8-channel converter front end.
// The input channel (in_valid_i / in_ready_o / sample_i) carries one finished
// conversion per transaction for the logical channel being scanned. The sample
// is added to that channel's 16-bit sum unless the channel is simulated.
// Every input transaction produces one mux selection result (kind 0, last 1)
// with the physical input for the next conversion. When the configured number
// of full passes completes, eight sum reports (kind 1, last 0) come first.
// The mux selection is loaded into the output register in state SEL, after
// state ACC has added the sample; a report passes through states RPT_RD and
// RPT_OUT per channel, since the sum memory has a registered read. A new
// input transaction is taken once the previous item's results are all loaded.
// The output register holds a result until the receiver takes it; a stalled
// receiver stops the sequencer but an input transaction is still accepted
// while the last result of the previous item waits.
// Reset clears the scan index, the pass count and all sums (through per-entry
// valid bits, so no clearing pass is needed) and loads the register defaults.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always accepted.
module adc_oversampling_scan_sequencer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aoss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [aoss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [aoss_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic [aoss_pkg::PHYS_W-1:0]         select_channel_o,
  output logic [aoss_pkg::RPT_IDX_W-1:0]      report_index_o,
  output logic [aoss_pkg::SUM_W-1:0]          report_sum_o,
  output logic                                last_o
);

  aoss_pkg::cfg_t cfg;

  aoss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  aoss_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .select_channel_o(select_channel_o),
    .report_index_o  (report_index_o),
    .report_sum_o    (report_sum_o),
    .last_o          (last_o)
  );

endmodule

[hw/rtl/aoss_ram.sv]
module aoss_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/aoss_cfg.sv]
module aoss_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aoss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [aoss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output aoss_pkg::cfg_t                      cfg_o
);

  aoss_pkg::cfg_t cfg_q;
  logic           wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_mask <= aoss_pkg::ENABLE_MASK_RESET;
      cfg_q.sim_mask <= aoss_pkg::SIM_MASK_RESET;
      cfg_q.passes <= aoss_pkg::PASSES_RESET;
    end else if (wr) begin
      case (cfg_index_i)
        aoss_pkg::CFG_ENABLE_MASK: cfg_q.enable_mask <= cfg_data_i;
        aoss_pkg::CFG_SIM_MASK: cfg_q.sim_mask <= cfg_data_i[aoss_pkg::SIM_W-1:0];
        aoss_pkg::CFG_PASSES: cfg_q.passes <= cfg_data_i[aoss_pkg::PASS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/aoss_seq.sv]
module aoss_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  aoss_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [aoss_pkg::SAMPLE_W-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 kind_o,
  output logic [aoss_pkg::PHYS_W-1:0]          select_channel_o,
  output logic [aoss_pkg::RPT_IDX_W-1:0]       report_index_o,
  output logic [aoss_pkg::SUM_W-1:0]           report_sum_o,
  output logic                                 last_o
);

  localparam int unsigned IdxW = aoss_pkg::IDX_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(aoss_pkg::CHANNELS - 1);

  aoss_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]                  idx_q, rpt_q;
  logic [aoss_pkg::PASS_W-1:0]      pass_q;
  logic [aoss_pkg::SAMPLE_W-1:0]    sample_q;
  logic [aoss_pkg::PHYS_W-1:0]      sel_q;
  logic [aoss_pkg::CHANNELS-1:0]    valid_q;

  logic                             out_valid_q;
  logic                             kind_q, last_q;
  logic [aoss_pkg::PHYS_W-1:0]      osel_q;
  logic [aoss_pkg::RPT_IDX_W-1:0]   oidx_q;
  logic [aoss_pkg::SUM_W-1:0]       osum_q;

  logic                             ram_we, ram_re;
  logic [IdxW-1:0]                  ram_waddr, ram_raddr;
  logic [aoss_pkg::SUM_W-1:0]       ram_rdata;

  logic                             accept, slot_free, wrap, rpt_hit, rpt_last;
  logic                             load_rpt, load_sel;
  logic [IdxW-1:0]                  idx_next;
  logic [aoss_pkg::PASS_W-1:0]      pass_inc;
  logic [aoss_pkg::SUM_W-1:0]       acc_old, acc_sum, rpt_sum;
  logic [aoss_pkg::CHANNELS-1:0]    keep_mask;

  aoss_ram #(
    .Width(aoss_pkg::SUM_W),
    .Depth(aoss_pkg::CHANNELS)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(acc_sum),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // An entry without its valid bit has been cleared and reads as zero.
  assign acc_old = valid_q[idx_q] ? ram_rdata : '0;
  assign acc_sum = acc_old + aoss_pkg::SUM_W'(sample_q);
  assign rpt_sum = valid_q[rpt_q] ? ram_rdata : '0;

  assign wrap = (idx_q == LastIdx);
  assign idx_next = wrap ? '0 : idx_q + IdxW'(1);
  assign pass_inc = pass_q + aoss_pkg::PASS_W'(1);
  assign rpt_hit = wrap && (pass_inc >= cfg_i.passes);
  assign rpt_last = (rpt_q == LastIdx);
  assign slot_free = !out_valid_q || out_ready_i;
  assign keep_mask = aoss_pkg::CHANNELS'(cfg_i.sim_mask);

  always_comb begin
    state_d = state_q;
    case (state_q)
      aoss_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = aoss_pkg::ST_ACC;
      end
      aoss_pkg::ST_ACC: begin
        state_d = rpt_hit ? aoss_pkg::ST_RPT_RD : aoss_pkg::ST_SEL;
      end
      aoss_pkg::ST_RPT_RD: begin
        state_d = aoss_pkg::ST_RPT_OUT;
      end
      aoss_pkg::ST_RPT_OUT: begin
        if (slot_free) state_d = rpt_last ? aoss_pkg::ST_SEL : aoss_pkg::ST_RPT_RD;
      end
      aoss_pkg::ST_SEL: begin
        if (slot_free) state_d = aoss_pkg::ST_IDLE;
      end
      default: state_d = aoss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_re = 1'b0;
    ram_raddr = idx_q;
    ram_we = 1'b0;
    ram_waddr = idx_q;
    load_rpt = 1'b0;
    load_sel = 1'b0;
    case (state_q)
      aoss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re = in_valid_i;
      end
      aoss_pkg::ST_ACC: begin
        ram_we = !cfg_i.sim_mask[idx_q];
      end
      aoss_pkg::ST_RPT_RD: begin
        ram_re = 1'b1;
        ram_raddr = rpt_q;
      end
      aoss_pkg::ST_RPT_OUT: begin
        load_rpt = slot_free;
      end
      aoss_pkg::ST_SEL: begin
        load_sel = slot_free;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aoss_pkg::ST_IDLE;
      idx_q <= '0;
      pass_q <= '0;
      rpt_q <= '0;
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == aoss_pkg::ST_ACC) begin
        idx_q <= idx_next;
        rpt_q <= '0;
        if (wrap) pass_q <= rpt_hit ? '0 : pass_inc;
        if (ram_we) valid_q[idx_q] <= 1'b1;
      end
      if (load_rpt) begin
        rpt_q <= rpt_q + IdxW'(1);
        // All sums have been reported; simulated channels keep theirs.
        if (rpt_last) valid_q <= valid_q & keep_mask;
      end
      if (load_rpt || load_sel) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) sample_q <= sample_i;
    if (state_q == aoss_pkg::ST_ACC) begin
      sel_q <= aoss_pkg::nth_enabled(cfg_i.enable_mask, idx_next);
    end
    if (load_rpt) begin
      kind_q <= aoss_pkg::KIND_REPORT;
      osel_q <= '0;
      oidx_q <= aoss_pkg::RPT_IDX_W'(rpt_q);
      osum_q <= rpt_sum;
      last_q <= 1'b0;
    end else if (load_sel) begin
      kind_q <= aoss_pkg::KIND_SELECT;
      osel_q <= sel_q;
      oidx_q <= '0;
      osum_q <= '0;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign select_channel_o = osel_q;
  assign report_index_o = oidx_q;
  assign report_sum_o = osum_q;
  assign last_o = last_q;

endmodule
